>>> hdl/pidpi_pkg.sv
package pidpi_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int ERR_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int DELTA_W    = ERR_W + 1;
    localparam int DDELTA_W   = ERR_W + 2;
    localparam int ACC_W      = 32;
    localparam int LIMIT_W    = 31;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 31;
    localparam int SUM_W      = 50;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_GAIN_P      = 3'd1,
        CFG_GAIN_I      = 3'd2,
        CFG_GAIN_D      = 3'd3,
        CFG_INTEG_LIMIT = 3'd4
    } cfg_index_t;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } pid_mode_t;

    typedef enum logic {
        ACT_PROCESS = 1'b0,
        ACT_CLEAR   = 1'b1
    } pid_action_t;

    typedef struct packed {
        pid_mode_t                 mode;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0]        integ_limit;
    } pid_cfg_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]   integ_sum;
        logic signed [ERR_W-1:0]   prev_error;
        logic signed [DELTA_W-1:0] prev_delta;
        logic signed [ACC_W-1:0]   acc_out;
    } pid_state_t;

endpackage

>>> hdl/pidpi_step.sv
module pidpi_step
    import pidpi_pkg::*;
(
    input  pid_cfg_t                cfg,
    input  pid_state_t              state,
    input  pid_action_t             action,
    input  logic signed [ERR_W-1:0] error_in,
    output pid_state_t              state_next,
    output logic signed [ACC_W-1:0] drive,
    output logic                    sat
);

    localparam logic signed [SUM_W:0] OUT_MAX = (SUM_W+1)'(64'sd2147483647);
    localparam logic signed [SUM_W:0] OUT_MIN = (SUM_W+1)'(-64'sd2147483648);

    logic signed [ACC_W:0]          integ_raw;
    logic signed [ACC_W:0]          limit_pos;
    logic signed [ACC_W:0]          limit_neg;
    logic signed [ACC_W:0]          integ_clamp;
    logic                           integ_hit;
    logic signed [DELTA_W-1:0]      delta;
    logic signed [DDELTA_W-1:0]     ddelta;
    logic signed [DELTA_W-1:0]      op_p;
    logic signed [ACC_W-1:0]        op_i;
    logic signed [DDELTA_W-1:0]     op_d;
    logic signed [GAIN_W+DELTA_W-1:0]  prod_p;
    logic signed [GAIN_W+ACC_W-1:0]    prod_i;
    logic signed [GAIN_W+DDELTA_W-1:0] prod_d;
    logic signed [SUM_W-1:0]        sum;
    logic signed [SUM_W-1:0]        sum_shift;
    logic signed [ACC_W-1:0]        base;
    logic signed [SUM_W:0]          total;
    logic signed [ACC_W-1:0]        total_sat;
    logic                           out_hit;
    logic                           incr;

    assign incr = (cfg.mode == MODE_INCREMENTAL);

    // integrator update and clamp (positional form)
    always_comb
    begin
        integ_raw = (ACC_W+1)'(state.integ_sum) + (ACC_W+1)'(error_in);
        limit_pos = $signed({2'b00, cfg.integ_limit});
        limit_neg = -limit_pos;
        integ_hit = 1'b0;
        integ_clamp = integ_raw;
        if (integ_raw > limit_pos)
        begin
            integ_clamp = limit_pos;
            integ_hit = 1'b1;
        end
        if (integ_raw < limit_neg)
        begin
            integ_clamp = limit_neg;
            integ_hit = 1'b1;
        end
    end

    assign delta  = DELTA_W'(error_in) - DELTA_W'(state.prev_error);
    assign ddelta = DDELTA_W'(delta) - DDELTA_W'(state.prev_delta);

    // one set of multipliers serves both forms
    assign op_p = incr ? delta : DELTA_W'(error_in);
    assign op_i = incr ? ACC_W'(error_in) : integ_clamp[ACC_W-1:0];
    assign op_d = incr ? ddelta : DDELTA_W'(delta);

    assign prod_p = cfg.gain_p * op_p;
    assign prod_i = cfg.gain_i * op_i;
    assign prod_d = cfg.gain_d * op_d;

    assign sum       = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);
    assign sum_shift = sum >>> FRAC_BITS;
    assign base      = incr ? state.acc_out : '0;
    assign total     = (SUM_W+1)'(sum_shift) + (SUM_W+1)'(base);

    always_comb
    begin
        out_hit = 1'b0;
        total_sat = total[ACC_W-1:0];
        if (total > OUT_MAX)
        begin
            total_sat = OUT_MAX[ACC_W-1:0];
            out_hit = 1'b1;
        end
        else if (total < OUT_MIN)
        begin
            total_sat = OUT_MIN[ACC_W-1:0];
            out_hit = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state;
        drive = total_sat;
        sat = out_hit || (!incr && integ_hit);
        if (action == ACT_CLEAR)
        begin
            state_next = '0;
            drive = '0;
            sat = 1'b0;
        end
        else
        begin
            state_next.prev_error = error_in;
            state_next.acc_out = total_sat;
            if (incr)
                state_next.prev_delta = delta;
            else
                state_next.integ_sum = integ_clamp[ACC_W-1:0];
        end
    end

endmodule

>>> hdl/pid_positional_incremental.sv
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    action, error_in
// out       output     out_valid/out_ready  drive_out, saturated
// cfg       input      cfg_wr_en            cfg_addr, cfg_wdata
//
// One item per cycle sustained while the output is not stalled; an input transfer
// passes through the input register, then one combinational step into the result
// register, where the controller state is updated in the same edge.
// rst_n clears gains, mode, limit, controller state and both valid flags.
// A stalled output holds the result; the input register keeps accepting
// until it too is full, then in_ready drops.
module pid_positional_incremental
    import pidpi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    action,
    input  logic signed [ERR_W-1:0] error_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ACC_W-1:0] drive_out,
    output logic                    saturated,
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    pid_cfg_t                cfg_reg;
    pid_state_t              state_reg;
    pid_state_t              state_next;
    logic                    in_valid_reg;
    pid_action_t             in_action_reg;
    logic signed [ERR_W-1:0] in_error_reg;
    logic                    out_valid_reg;
    logic signed [ACC_W-1:0] drive_reg;
    logic signed [ACC_W-1:0] drive_next;
    logic                    sat_reg;
    logic                    sat_next;
    logic                    advance;
    logic                    in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_MODE:        cfg_reg.mode <= pid_mode_t'(cfg_wdata[0]);
                CFG_GAIN_P:      cfg_reg.gain_p <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_I:      cfg_reg.gain_i <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:      cfg_reg.gain_d <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_LIMIT: cfg_reg.integ_limit <= cfg_wdata[LIMIT_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    pidpi_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .action     (in_action_reg),
        .error_in   (in_error_reg),
        .state_next (state_next),
        .drive      (drive_next),
        .sat        (sat_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg <= pid_action_t'(action);
            in_error_reg  <= error_in;
        end
        if (advance)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_out = drive_reg;
    assign saturated = sat_reg;

endmodule

>>> hdl/pidpi_checker.sv
module pidpi_checker
    import pidpi_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [ACC_W-1:0] drive_out,
    input logic                    saturated
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_out) && $stable(saturated))
        else $error("output changed while stalled");

    // backpressure only when the result register is full
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with output free");

    // a fresh result follows an input transfer through the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching input transfer");

    // reset empties the output
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after reset");

endmodule

bind pid_positional_incremental pidpi_checker u_pidpi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive_out (drive_out),
    .saturated (saturated)
);
